// File: design/bpa_pkg.sv
// Shared constants and types for the bitmap page allocator.
// No dependencies; imported by the engine and the top level.
package bpa_pkg;
  localparam int NumPagesDef = 32768;
  localparam int StartFieldPages = 32768;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RESERVE = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADRNG  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] base_page;
    logic [15:0] page_limit;
    logic [15:0] page_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] start_page;
  } rsp_t;
endpackage

// File: design/bpa_engine.sv
// Bitmap memory and the page-at-a-time sequencer that searches and marks it.
// Depends on bpa_pkg.
module bpa_engine #(
  parameter int PAGE_TOTAL = bpa_pkg::NumPagesDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  bpa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bpa_pkg::rsp_t rsp
);
  import bpa_pkg::*;

  localparam int MapBytes = (PAGE_TOTAL + 7) / 8;
  localparam int AW = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  // wide enough for page numbers and for base page plus a 16-bit count
  localparam int PW = ($clog2(PAGE_TOTAL) + 2 > 18) ? $clog2(PAGE_TOTAL) + 2 : 18;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCHK  = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;
  localparam logic [3:0] S_MWR   = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;

  logic [7:0] mem [MapBytes];
  logic [7:0] rdata_r;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata;

  logic [3:0]  state_r, state_nxt;
  logic [PW-1:0] p_r, p_nxt, bound_r, bound_nxt, end_r, end_nxt;
  logic [PW-1:0] rs_r, rs_nxt, len_r, len_nxt, cnt_r, cnt_nxt;
  logic        used_r, used_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  rsp_t        rsp_r, rsp_nxt;

  logic [PW-1:0] lim_e, np_e, first_e, cnt_e;
  logic [AW-1:0] paddr;
  logic          pbit;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign paddr = AW'(p_r >> 3);
  assign raddr = paddr;
  assign pbit  = rdata_r[p_r[2:0]];
  assign lim_e   = PW'(req.page_limit);
  assign np_e    = PW'(PAGE_TOTAL);
  assign first_e = PW'(req.base_page);
  assign cnt_e   = PW'(req.page_count);

  always_comb begin
    state_nxt = state_r;
    p_nxt = p_r; bound_nxt = bound_r; end_nxt = end_r;
    rs_nxt = rs_r; len_nxt = len_r; cnt_nxt = cnt_r;
    used_nxt = used_r; clr_nxt = clr_r; rsp_nxt = rsp_r;
    we = 1'b0; waddr = paddr; wdata = rdata_r;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r; wdata = 8'hFF;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MapBytes - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          rsp_nxt = '{status: ST_OK, start_page: '0};
          p_nxt = first_e; len_nxt = '0; cnt_nxt = cnt_e;
          bound_nxt = (lim_e < np_e) ? lim_e : np_e;
          if (req.kind == KIND_ALLOC) begin
            rsp_nxt.status = ST_NOSPACE;
            state_nxt = (cnt_e == '0) ? S_DONE : S_SRD;
          end else if (req.kind == KIND_RESERVE || req.kind == KIND_RELEASE) begin
            used_nxt = (req.kind == KIND_RESERVE);
            end_nxt = first_e + cnt_e;
            if (first_e + cnt_e > np_e) begin
              rsp_nxt.status = ST_BADRNG;
              state_nxt = S_DONE;
            end else state_nxt = (cnt_e == '0) ? S_DONE : S_MRD;
          end else begin
            rsp_nxt.status = ST_BADRNG;
            state_nxt = S_DONE;
          end
        end
      end
      S_SRD: state_nxt = (p_r < bound_r) ? S_SCHK : S_DONE;
      S_SCHK: begin
        // advance one page per read; run resets on a used page
        if (pbit) begin
          len_nxt = '0; p_nxt = p_r + PW'(1); state_nxt = S_SRD;
        end else if (len_r == '0 && p_r >= PW'(StartFieldPages)) begin
          state_nxt = S_DONE;
        end else begin
          if (len_r == '0) rs_nxt = p_r;
          len_nxt = len_r + PW'(1);
          p_nxt = p_r + PW'(1);
          state_nxt = S_SRD;
          if (len_r + PW'(1) == cnt_r) begin
            rsp_nxt = '{status: ST_OK, start_page: (len_r == '0) ? p_r[14:0] : rs_r[14:0]};
            p_nxt = (len_r == '0) ? p_r : rs_r;
            end_nxt = ((len_r == '0) ? p_r : rs_r) + cnt_r;
            used_nxt = 1'b1;
            state_nxt = S_MRD;
          end
        end
      end
      S_MRD: state_nxt = S_MWR;
      S_MWR: begin
        we = 1'b1;
        wdata[p_r[2:0]] = used_r;
        p_nxt = p_r + PW'(1);
        // one page per read-modify-write keeps read data coherent
        state_nxt = (p_r + PW'(1) == end_r) ? S_DONE : S_MRD;
      end
      S_DONE: if (rsp_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt;
    end
    p_r <= p_nxt; bound_r <= bound_nxt; end_r <= end_nxt; rs_r <= rs_nxt;
    len_r <= len_nxt; cnt_r <= cnt_nxt; used_r <= used_nxt; rsp_r <= rsp_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_DONE);
  assign rsp = rsp_r;

  a_ok_start: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid && rsp.status != ST_OK |-> rsp.start_page == '0) else $error("start nonzero");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req_ready && rsp_valid)) else $error("ready while result held");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MWR |-> $past(state_r) == S_MRD) else $error("write without read");
endmodule

// File: design/bitmap_page_allocator.sv
// Bitmap page allocator: one request item in, one status item out, one item in
// flight at a time. The bitmap sits in a byte memory with one read port and one
// write port; each page takes a read state and then a check or modify state. An
// allocate searches page by page and then marks the run it found; a reserve or
// release marks its pages one by one; a zero-length, out-of-range or unknown
// request is answered without touching the bitmap. A result is held while
// out_tready is low. After reset a clearing pass writes every byte of the bitmap
// to mark every page used before in_tready first rises.
module bitmap_page_allocator #(
  parameter int PAGE_TOTAL = bpa_pkg::NumPagesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind
  input  logic [47:0] in_tdata,   // base_page[14:0], page_limit[30:15], page_count[46:31]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[1:0], start_page[16:2]
);
  import bpa_pkg::*;
  req_t req;
  rsp_t rsp;

  assign req = '{kind: in_tuser, base_page: in_tdata[14:0],
                 page_limit: in_tdata[30:15], page_count: in_tdata[46:31]};
  assign out_tdata = {7'd0, rsp.start_page, rsp.status};

  bpa_engine #(.PAGE_TOTAL(PAGE_TOTAL)) u_eng (
    .clk, .rst_n, .req_valid(in_tvalid), .req_ready(in_tready), .req,
    .rsp_valid(out_tvalid), .rsp_ready(out_tready), .rsp
  );
endmodule

// File: tb/bitmap_page_allocator_tb.sv
// Testbench for bitmap_page_allocator: directed and random allocate, reserve and
// release items are checked against a page bitmap kept inside the bench.
// Depends on bpa_pkg and the bitmap_page_allocator RTL only.
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int NumPages   = 32768;
  localparam int CycleLimit = 4000000;
  localparam int NumRandom  = 1600;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic [14:0] start_page;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  bit            page_used [NumPages];
  alloc_result_t pending_results[$];
  int            mismatches;
  int            cycle_cnt;
  int            burst_left;
  int            stall_mode;
  int            window_base[8];

  bitmap_page_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[bitmap_page_allocator] ERROR");
      $finish;
    end
  end

  // Apply one request to the page bitmap and return the status it answers with.
  function automatic alloc_result_t apply_request(logic [1:0] kind, int first, int limit,
                                                  int count);
    alloc_result_t res;
    int bound;
    int run_start;
    int run_len;
    bit found;
    res.status = ST_OK;
    res.start_page = '0;
    run_start = 0;
    run_len = 0;
    found = 1'b0;
    if (kind == KIND_ALLOC) begin
      bound = (limit < NumPages) ? limit : NumPages;
      res.status = ST_NOSPACE;
      if (count != 0) begin
        for (int p = first; p < bound; p++) begin
          if (page_used[p]) begin
            run_len = 0;
            continue;
          end
          if (run_len == 0) begin
            if (p >= StartFieldPages) break;
            run_start = p;
          end
          run_len++;
          if (run_len == count) begin
            found = 1'b1;
            break;
          end
        end
      end
      if (found) begin
        for (int i = 0; i < count; i++) page_used[run_start + i] = 1'b1;
        res.status = ST_OK;
        res.start_page = run_start[14:0];
      end
    end else if (kind == KIND_RESERVE || kind == KIND_RELEASE) begin
      if (first + count > NumPages) begin
        res.status = ST_BADRNG;
      end else begin
        for (int i = 0; i < count; i++) page_used[first + i] = (kind == KIND_RESERVE);
      end
    end else begin
      res.status = ST_BADRNG;
    end
    return res;
  endfunction

  task automatic send_request(logic [1:0] kind, int first, int limit, int count);
    logic [14:0] f;
    logic [15:0] l;
    logic [15:0] c;
    f = first[14:0];
    l = limit[15:0];
    c = count[15:0];
    if (burst_left == 0) begin
      // gap before the next burst so valid is not dropped and raised in one step
      repeat ($urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tuser  <= kind;
    in_tdata  <= {1'b0, c, l, f};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(kind, int'(f), int'(l), int'(c)));
    burst_left--;
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    if (burst_left != 0) begin
      burst_left = 0;
      in_tvalid <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Check each result item against the oldest prediction; vary the stall pattern.
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", out_tdata);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_tdata[1:0] !== exp_res.status || out_tdata[16:2] !== exp_res.start_page ||
              out_tdata[23:17] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d page %0d, got status %0d page %0d",
                       exp_res.status, exp_res.start_page, out_tdata[1:0], out_tdata[16:2]);
          end
        end
      end
      if (cycle_cnt % 400 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  task automatic test_range_edges();
    send_request(KIND_ALLOC, 0, NumPages, 1);       // full walk over a used map
    send_request(KIND_RELEASE, 0, 0, NumPages);     // whole map free
    send_request(KIND_RESERVE, 32767, 0, 2);        // one past the end
    send_request(KIND_RESERVE, 0, 0, 65535);
    send_request(KIND_RELEASE, 32767, 65535, 65535);
    send_request(KIND_UNKNOWN, 32767, 65535, 65535);
    send_request(KIND_RESERVE, 0, 0, 0);
    send_request(KIND_RELEASE, 32767, 0, 0);
    send_request(KIND_RESERVE, 0, 0, NumPages);     // whole map used
    drain_results();
  endtask

  task automatic test_alloc_cases();
    send_request(KIND_ALLOC, 5, 100, 0);            // zero pages
    send_request(KIND_RELEASE, 3, 0, 13);           // unaligned range
    send_request(KIND_ALLOC, 0, 20, 13);
    send_request(KIND_ALLOC, 0, 20, 1);
    send_request(KIND_RELEASE, 100, 0, 40);
    send_request(KIND_ALLOC, 100, 65535, 5);        // bound above the map
    send_request(KIND_ALLOC, 101, 120, 30);         // does not fit below bound
    send_request(KIND_RELEASE, 32760, 0, 8);
    send_request(KIND_ALLOC, 32760, NumPages, 8);
    send_request(KIND_RELEASE, 32767, 0, 1);
    send_request(KIND_ALLOC, 32765, 65535, 4);
    send_request(KIND_ALLOC, 32767, NumPages, 1);
    send_request(KIND_ALLOC, 110, 110, 1);          // empty search window
    drain_results();
  endtask

  task automatic test_random_traffic();
    int w;
    int first;
    int limit;
    int count;
    int pick;
    window_base[0] = 0;
    window_base[1] = NumPages - 256;
    for (int i = 2; i < 8; i++) window_base[i] = $urandom_range(0, 32512);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain_results();
      w = window_base[$urandom_range(0, 7)];
      first = w + $urandom_range(0, 200);
      if (first > 32767) first = 32767;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        limit = first + $urandom_range(0, 120);
        if (first > 32600 && $urandom_range(0, 1)) limit = $urandom_range(32768, 65535);
        send_request(KIND_ALLOC, first, limit, $urandom_range(1, 24));
      end else if (pick < 70) begin
        send_request(KIND_RELEASE, first, $urandom_range(0, 65535), $urandom_range(1, 40));
      end else if (pick < 96) begin
        send_request(KIND_RESERVE, first, $urandom_range(0, 65535), $urandom_range(0, 40));
      end else if (pick < 98) begin
        send_request(KIND_UNKNOWN, $urandom_range(0, 32767), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
      end else begin
        first = $urandom_range(0, 32767);
        count = $urandom_range(32769 - first, 65535);
        send_request($urandom_range(0, 1) ? KIND_RESERVE : KIND_RELEASE, first,
                     $urandom_range(0, 65535), count);
      end
    end
    drain_results();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= '0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    mismatches = 0;
    cycle_cnt  = 0;
    burst_left = 0;
    stall_mode = 0;
    for (int p = 0; p < NumPages; p++) page_used[p] = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_range_edges();
    test_alloc_cases();
    test_random_traffic();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[bitmap_page_allocator] OK");
    end else begin
      $display("[bitmap_page_allocator] ERROR");
    end
    $finish;
  end
endmodule
